// File: sv/scma_pkg.sv
// ----------------------------------------------------------------------------
// scma_pkg
// Shared widths, register codes, reset values and the block descriptor type
// of the centered moving average core.
// ----------------------------------------------------------------------------
package scma_pkg;

  localparam int BLOCK_MAX_DEF     = 64;
  localparam int HISTORY_DEPTH_DEF = 64;

  localparam int SAMPLE_W  = 16;
  localparam int CNT_W     = 7;
  localparam int WS_W      = 7;
  localparam int INV_W     = 17;
  localparam int CFG_W     = 17;
  localparam int CFG_IDX_W = 1;
  localparam int AVG_W     = 32;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_INV_WINDOW  = 1'b1;

  localparam logic [WS_W-1:0]  WS_RESET  = 7'd5;
  localparam logic [INV_W-1:0] INV_RESET = 17'd13107;
  localparam logic [INV_W-1:0] INV_MAX   = 17'h10000;

  typedef struct packed {
    logic                       bank;
    logic [CNT_W-1:0]           count;
    logic                       all_equal;
    logic signed [SAMPLE_W-1:0] first;
  } scma_desc_t;

endpackage

// File: sv/scma_front.sv
// ----------------------------------------------------------------------------
// scma_front
// Input side: writes samples into a two-bank block buffer, tracks the count
// and the all-equal flag, and issues one descriptor per closed block.
// ----------------------------------------------------------------------------
module scma_front import scma_pkg::*; #(
  parameter  int BLOCK_MAX = BLOCK_MAX_DEF,
  localparam int BAW       = $clog2(2 * BLOCK_MAX)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic signed [SAMPLE_W-1:0] sample_i,
  input  logic                       block_end_i,
  output logic                       push_o,
  output scma_desc_t                 desc_o,
  input  logic                       done_i,
  input  logic [BAW-1:0]             rd_addr_i,
  output logic signed [SAMPLE_W-1:0] rd_data_o
);

  logic [CNT_W-1:0]           count_q;
  logic                       all_eq_q;
  logic signed [SAMPLE_W-1:0] first_q;
  logic                       bank_q;
  logic [1:0]                 outst_q;
  logic signed [SAMPLE_W-1:0] mem [2*BLOCK_MAX];

  logic                       accept;
  logic signed [SAMPLE_W-1:0] first_n;
  logic                       all_eq_n;
  logic [CNT_W-1:0]           count_n;
  logic                       close;
  logic [BAW-1:0]             wr_addr;

  assign in_stall_o = (outst_q == 2'd2);
  assign accept     = in_valid_i & ~in_stall_o;
  assign first_n    = (count_q == '0) ? sample_i : first_q;
  assign all_eq_n   = (count_q == '0) | (all_eq_q & (sample_i == first_q));
  assign count_n    = count_q + 1'b1;
  assign close      = block_end_i | (count_n == CNT_W'(BLOCK_MAX));
  assign wr_addr    = bank_q ? BAW'(count_q) + BAW'(BLOCK_MAX) : BAW'(count_q);

  assign push_o = accept & close;
  assign desc_o = '{bank: bank_q, count: count_n, all_equal: all_eq_n, first: first_n};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      all_eq_q <= 1'b1;
      bank_q   <= 1'b0;
    end else if (accept) begin
      if (close) begin
        count_q  <= '0;
        all_eq_q <= 1'b1;
        bank_q   <= ~bank_q;
      end else begin
        count_q  <= count_n;
        all_eq_q <= all_eq_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      outst_q <= '0;
    end else if (push_o && !done_i) begin
      outst_q <= outst_q + 2'd1;
    end else if (!push_o && done_i) begin
      outst_q <= outst_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      first_q <= first_n;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mem[wr_addr] <= sample_i;
    end
    rd_data_o <= mem[rd_addr_i];
  end

endmodule

// File: sv/scma_queue.sv
// ----------------------------------------------------------------------------
// scma_queue
// Two-entry descriptor queue between the input side and the run engine.
// ----------------------------------------------------------------------------
module scma_queue import scma_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  scma_desc_t desc_i,
  input  logic       pop_i,
  output logic       empty_o,
  output scma_desc_t desc_o
);

  scma_desc_t ent_q [2];
  logic       wr_q;
  logic       rd_q;
  logic [1:0] cnt_q;

  assign empty_o = (cnt_q == 2'd0);
  assign desc_o  = ent_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= ~wr_q;
      end
      if (pop_i) begin
        rd_q <= ~rd_q;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (!push_i && pop_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wr_q] <= desc_i;
    end
  end

endmodule

// File: sv/scma_back.sv
// ----------------------------------------------------------------------------
// scma_back
// Run engine: replays a buffered block through the history line, updates the
// running average and drives the registered result output.
// ----------------------------------------------------------------------------
module scma_back import scma_pkg::*; #(
  parameter  int BLOCK_MAX     = BLOCK_MAX_DEF,
  parameter  int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
  localparam int BAW           = $clog2(2 * BLOCK_MAX)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       empty_i,
  input  scma_desc_t                 desc_i,
  output logic                       pop_o,
  output logic                       done_o,
  output logic [BAW-1:0]             rd_addr_o,
  input  logic signed [SAMPLE_W-1:0] rd_data_i,
  input  logic [WS_W-1:0]            window_size_i,
  input  logic [INV_W-1:0]           inv_window_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic signed [SAMPLE_W-1:0] smoothed_o,
  output logic                       run_last_o
);

  localparam int HPW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int CW  = (HPW + 1 > WS_W) ? HPW + 1 : WS_W;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_READ = 3'd1;
  localparam logic [2:0] ST_MUL  = 3'd2;
  localparam logic [2:0] ST_ACC  = 3'd3;
  localparam logic [2:0] ST_EMIT = 3'd4;

  logic [2:0]                 state_q;
  scma_desc_t                 desc_q;
  logic [CNT_W-1:0]           idx_q;
  logic signed [AVG_W-1:0]    avg_q;
  logic signed [34:0]         prod_q;
  logic signed [SAMPLE_W-1:0] x_q;
  logic [HPW-1:0]             hptr_q;
  logic [HISTORY_DEPTH-1:0]   hval_q;
  logic signed [SAMPLE_W-1:0] hmem [HISTORY_DEPTH];
  logic signed [SAMPLE_W-1:0] hrd_q;
  logic                       hrv_q;
  logic                       out_valid_q;
  logic signed [SAMPLE_W-1:0] smoothed_q;
  logic                       run_last_q;

  logic [CW-1:0]              d_raw;
  logic [CW-1:0]              d_cl;
  logic [CW-1:0]              p_ext;
  logic [CW-1:0]              hraddr_w;
  logic [HPW-1:0]             hraddr;
  logic [INV_W-1:0]           inv_cl;
  logic signed [SAMPLE_W-1:0] old;
  logic signed [SAMPLE_W:0]   diff;
  logic signed [34:0]         prod_d;
  logic signed [35:0]         sum;
  logic signed [AVG_W-1:0]    avg_upd;
  logic signed [AVG_W:0]      eq_sum;
  logic signed [AVG_W:0]      rnd;
  logic signed [16:0]         r17;
  logic signed [SAMPLE_W-1:0] sm;
  logic                       last;
  logic                       emit_ok;

  assign d_raw    = CW'({window_size_i[WS_W-1:1], 1'b0});
  assign d_cl     = (d_raw > CW'(HISTORY_DEPTH)) ? CW'(HISTORY_DEPTH) : d_raw;
  assign p_ext    = CW'(hptr_q);
  assign hraddr_w = (p_ext >= d_cl) ? p_ext - d_cl : p_ext + CW'(HISTORY_DEPTH) - d_cl;
  assign hraddr   = hraddr_w[HPW-1:0];
  assign inv_cl   = (inv_window_i > INV_MAX) ? INV_MAX : inv_window_i;

  assign old    = (d_cl == '0) ? rd_data_i : (hrv_q ? hrd_q : '0);
  assign diff   = (SAMPLE_W+1)'(rd_data_i) - (SAMPLE_W+1)'(old);
  assign prod_d = 35'(diff) * 35'($signed({1'b0, inv_cl}));

  assign sum = 36'(avg_q) + 36'(prod_q);
  always_comb begin
    if (sum[35:31] != {5{sum[35]}}) begin
      avg_upd = sum[35] ? {1'b1, {(AVG_W-1){1'b0}}} : {1'b0, {(AVG_W-1){1'b1}}};
    end else begin
      avg_upd = sum[AVG_W-1:0];
    end
  end

  assign eq_sum = (AVG_W+1)'(avg_q) + (AVG_W+1)'($signed({desc_i.first, 16'h0000}));

  assign rnd = (AVG_W+1)'(avg_q) + 33'sd32768;
  assign r17 = rnd[AVG_W:16];
  assign sm  = (r17[16] != r17[15]) ? (r17[16] ? 16'sh8000 : 16'sh7FFF) : r17[15:0];

  assign last      = (idx_q == desc_q.count - 1'b1);
  assign emit_ok   = (state_q == ST_EMIT) && (!out_valid_q || !out_stall_i);
  assign pop_o     = (state_q == ST_IDLE) && !empty_i;
  assign done_o    = emit_ok && last;
  assign rd_addr_o = desc_q.bank ? BAW'(idx_q) + BAW'(BLOCK_MAX) : BAW'(idx_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
      avg_q   <= '0;
      hptr_q  <= '0;
      hval_q  <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (!empty_i) begin
            idx_q   <= '0;
            state_q <= ST_READ;
            if (desc_i.all_equal) begin
              avg_q <= eq_sum[AVG_W:1];
            end
          end
        end
        ST_READ: state_q <= ST_MUL;
        ST_MUL:  state_q <= ST_ACC;
        ST_ACC: begin
          avg_q          <= avg_upd;
          hval_q[hptr_q] <= 1'b1;
          hptr_q         <= (hptr_q == HPW'(HISTORY_DEPTH - 1)) ? '0 : hptr_q + 1'b1;
          state_q        <= ST_EMIT;
        end
        ST_EMIT: begin
          if (emit_ok) begin
            if (last) begin
              state_q <= ST_IDLE;
            end else begin
              idx_q   <= idx_q + 1'b1;
              state_q <= ST_READ;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      desc_q <= desc_i;
    end
    if (state_q == ST_MUL) begin
      prod_q <= prod_d;
      x_q    <= rd_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_ACC) begin
      hmem[hptr_q] <= x_q;
    end
    hrd_q <= hmem[hraddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hrv_q <= 1'b0;
    end else begin
      hrv_q <= hval_q[hraddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit_ok) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_ok) begin
      smoothed_q <= sm;
      run_last_q <= last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign smoothed_o  = smoothed_q;
  assign run_last_o  = run_last_q;

endmodule

// File: sv/streaming_centered_moving_average_core.sv
// Centered moving average core. Samples are taken one per cycle when not
// stalled into one of two block banks; a block closes on block_end or after
// BLOCK_MAX samples and is then replayed by the run engine, taking each
// sample through bank read, multiply, accumulate and emit before the next.
// While one bank is replayed the other keeps filling, so input stalls only
// when both banks hold closed blocks. The history line resets to zeros
// through per-entry valid bits, so no clearing pass follows reset.
// ----------------------------------------------------------------------------
// streaming_centered_moving_average_core
// Top level: configuration registers, input side, descriptor queue and run
// engine.
// ----------------------------------------------------------------------------
module streaming_centered_moving_average_core import scma_pkg::*; #(
  parameter int BLOCK_MAX     = BLOCK_MAX_DEF,
  parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic signed [SAMPLE_W-1:0] sample_i,
  input  logic                       block_end_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic signed [SAMPLE_W-1:0] smoothed_o,
  output logic                       run_last_o,
  input  logic                       cfg_we_i,
  input  logic [CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [CFG_W-1:0]           cfg_wdata_i
);

  localparam int BAW = $clog2(2 * BLOCK_MAX);

  logic [WS_W-1:0]            window_size_q;
  logic [INV_W-1:0]           inv_window_q;
  logic                       push;
  logic                       pop;
  logic                       empty;
  logic                       done;
  scma_desc_t                 desc_in;
  scma_desc_t                 desc_out;
  logic [BAW-1:0]             rd_addr;
  logic signed [SAMPLE_W-1:0] rd_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_size_q <= WS_RESET;
      inv_window_q  <= INV_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_WINDOW_SIZE: window_size_q <= cfg_wdata_i[WS_W-1:0];
        REG_INV_WINDOW:  inv_window_q  <= cfg_wdata_i[INV_W-1:0];
        default: ;
      endcase
    end
  end

  scma_front #(
    .BLOCK_MAX(BLOCK_MAX)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sample_i   (sample_i),
    .block_end_i(block_end_i),
    .push_o     (push),
    .desc_o     (desc_in),
    .done_i     (done),
    .rd_addr_i  (rd_addr),
    .rd_data_o  (rd_data)
  );

  scma_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .desc_i (desc_in),
    .pop_i  (pop),
    .empty_o(empty),
    .desc_o (desc_out)
  );

  scma_back #(
    .BLOCK_MAX    (BLOCK_MAX),
    .HISTORY_DEPTH(HISTORY_DEPTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .empty_i      (empty),
    .desc_i       (desc_out),
    .pop_o        (pop),
    .done_o       (done),
    .rd_addr_o    (rd_addr),
    .rd_data_i    (rd_data),
    .window_size_i(window_size_q),
    .inv_window_i (inv_window_q),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .smoothed_o   (smoothed_o),
    .run_last_o   (run_last_o)
  );

endmodule

// File: sv/scma_checker.sv
// ----------------------------------------------------------------------------
// scma_checker
// Port-level checks of the centered moving average core, bound to the top.
// ----------------------------------------------------------------------------
module scma_checker import scma_pkg::*; #(
  parameter int BLOCK_MAX = BLOCK_MAX_DEF
) (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_stall_o,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input logic signed [SAMPLE_W-1:0] smoothed_o,
  input logic                       run_last_o
);

  localparam int PW = $clog2(2 * BLOCK_MAX + 2) + 1;

  logic [PW-1:0] pend_q;
  logic          in_acc;
  logic          out_acc;

  assign in_acc  = in_valid_i & ~in_stall_o;
  assign out_acc = out_valid_o & ~out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else if (in_acc && !out_acc) begin
      pend_q <= pend_q + 1'b1;
    end else if (!in_acc && out_acc) begin
      pend_q <= pend_q - 1'b1;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(smoothed_o) && $stable(run_last_o))
    else $error("result changed while stalled");

  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pend_q != '0)
    else $error("result without a pending item");

  a_stall_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> pend_q != '0)
    else $error("input stalled with nothing pending");

  a_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= PW'(2 * BLOCK_MAX + 1))
    else $error("too many items pending");

endmodule

bind streaming_centered_moving_average_core scma_checker #(
  .BLOCK_MAX(BLOCK_MAX)
) u_scma_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .smoothed_o (smoothed_o),
  .run_last_o (run_last_o)
);
